// File: rtl/temperature_moving_average_defines.svh
// Assertion macros for the temperature moving average block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEMPERATURE_MOVING_AVERAGE_DEFINES_SVH
`define TEMPERATURE_MOVING_AVERAGE_DEFINES_SVH
`ifndef SYNTH
`define TMA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tma: same-cycle check failed");
`define TMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tma: next-cycle check failed");
`else
`define TMA_ASSERT(lbl, ante, cons)
`define TMA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// Widths, register indexes and types for the temperature moving average.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int RAW_W   = 16;
  localparam int SMP_W   = 14;                    // signed sample, 1/32 degree
  localparam int FRAC_W  = 4;                     // extra fraction bits
  localparam int OUT_W   = SMP_W + FRAC_W;        // 1/512 degree
  localparam int WIN_MAX = 64;
  localparam int PTR_W   = $clog2(WIN_MAX);
  localparam int CNT_W   = PTR_W + 1;             // holds 1..WIN_MAX
  localparam int WSZ_W   = 7;                     // window_size field
  localparam int SUM_W   = SMP_W + PTR_W + 1;
  localparam int DVD_W   = SUM_W - 1 + FRAC_W;    // |sum| * 16
  localparam int CYC_W   = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 8'd0,
    REG_SMOOTH = 8'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_SGN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// File: rtl/tma_in_if.sv
// ----------------------------------------------------------------------------
// tma_in_if
// Sensor word channel: raw register word and bus read status.
// ----------------------------------------------------------------------------
interface tma_in_if;
  logic                       valid;
  logic                       ready;
  logic [tma_pkg::RAW_W-1:0]  raw_word;
  logic                       read_ok;

  modport source (output valid, output raw_word, output read_ok, input ready);
  modport sink   (input valid, input raw_word, input read_ok, output ready);
endinterface

// File: rtl/tma_out_if.sv
// ----------------------------------------------------------------------------
// tma_out_if
// Result channel: temperature or average and its valid flag.
// ----------------------------------------------------------------------------
interface tma_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tma_pkg::OUT_W-1:0]  temp_value;
  logic                              valid_res;

  modport source (output valid, output temp_value, output valid_res, input ready);
  modport sink   (input valid, input temp_value, input valid_res, output ready);
endinterface

// File: rtl/tma_cfg_if.sv
// ----------------------------------------------------------------------------
// tma_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tma_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tma_pkg::CFG_IDX_W-1:0]  index;
  logic [tma_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/temperature_moving_average.sv
// Averaging word path from accept to the output register: ring read, sum
//   update, sign split, bit-serial divider, load. Pass-through and
//   failed-read words go straight to the load, which waits while a result
//   is still held unaccepted. A new word is accepted only in S_IDLE, once
//   the last one is loaded; the divider yields one quotient bit per cycle.
// Reset (synchronous, rst_n low): window 8, smoothing off, history cleared.
// ----------------------------------------------------------------------------
// temperature_moving_average
// Moving average of signed sensor samples over a ring buffer (pass-through
// when smoothing is off), with a bit-serial restoring divider for sum / count.
// ----------------------------------------------------------------------------
`include "temperature_moving_average_defines.svh"

module temperature_moving_average (
  input  logic       clk,
  input  logic       rst_n,
  tma_in_if.sink     in_if,
  tma_out_if.source  out_if,
  tma_cfg_if.sink    cfg_if
);
  import tma_pkg::*;

  state_t                   state_r, state_nxt;
  logic [WSZ_W-1:0]         win_r;
  logic                     smooth_r;
  logic [PTR_W-1:0]         pos_r, pos_nxt;
  logic                     primed_r, primed_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SMP_W-1:0]  smp_r, smp_nxt;
  logic [SMP_W-1:0]         rd_r;
  logic [SMP_W-1:0]         ring [WIN_MAX];
  logic [CNT_W-1:0]         div_r, div_nxt;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [OUT_W-1:0]         quo_r, quo_nxt;
  logic                     neg_r, neg_nxt;
  logic                     ok_r, ok_nxt;
  logic [CYC_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_temp_r, out_temp_nxt;
  logic                     out_ok_r, out_ok_nxt;

  logic                     in_acc, cfg_acc, clr;
  logic [CNT_W-1:0]         win_eff, pos_inc;
  logic [PTR_W-1:0]         pos_eff;
  logic                     wrap;
  logic [SMP_W-1:0]         old_smp;
  logic signed [SMP_W:0]    diff;
  logic [SUM_W-1:0]         mag;
  logic [CNT_W:0]           trial;
  logic [CNT_W:0]           shifted;
  logic                     ge;
  logic                     rd_en, wr_en;
  logic signed [SMP_W-1:0]  in_smp;

  assign in_acc  = in_if.valid && in_if.ready;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;
  assign clr     = cfg_acc && (cfg_if.index == REG_WINDOW || cfg_if.index == REG_SMOOTH);
  assign in_smp  = in_if.raw_word[RAW_W-1:RAW_W-SMP_W];

  assign in_if.ready       = (state_r == S_IDLE);
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.temp_value = out_temp_r;
  assign out_if.valid_res  = out_ok_r;

  // window 0 acts as 1, oversize saturates
  always_comb begin
    if (win_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (win_r > WSZ_W'(WIN_MAX)) begin
      win_eff = CNT_W'(WIN_MAX);
    end else begin
      win_eff = CNT_W'(win_r);
    end
  end

  assign pos_eff = (CNT_W'(pos_r) >= win_eff) ? '0 : pos_r;
  assign pos_inc = CNT_W'(pos_eff) + CNT_W'(1);
  assign wrap    = (pos_inc >= win_eff);
  // before the ring has wrapped, the slot about to be overwritten is still empty
  assign old_smp = primed_r ? rd_r : '0;
  assign diff    = {smp_r[SMP_W-1], smp_r} - {old_smp[SMP_W-1], old_smp};
  assign mag     = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign ge      = !trial[CNT_W];

  assign rd_en = (state_r == S_IDLE) && in_acc && in_if.read_ok && smooth_r;
  assign wr_en = (state_r == S_RD);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    primed_nxt    = primed_r;
    sum_nxt       = sum_r;
    smp_nxt       = smp_r;
    div_nxt       = div_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    ok_nxt        = ok_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_temp_nxt  = out_temp_r;
    out_ok_nxt    = out_ok_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_nxt = in_smp;
          neg_nxt = 1'b0;
          ok_nxt  = in_if.read_ok;
          if (!in_if.read_ok) begin
            quo_nxt   = '0;
            state_nxt = S_OUT;
          end else if (!smooth_r) begin
            quo_nxt   = {in_smp, {FRAC_W{1'b0}}};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        sum_nxt    = sum_r + {{(SUM_W-SMP_W-1){diff[SMP_W]}}, diff};
        pos_nxt    = wrap ? '0 : pos_inc[PTR_W-1:0];
        primed_nxt = primed_r || wrap;
        div_nxt    = (primed_r || wrap) ? win_eff : pos_inc;
        state_nxt  = S_SGN;
      end
      S_SGN: begin
        neg_nxt   = sum_r[SUM_W-1];
        dvd_nxt   = {mag[SUM_W-2:0], {FRAC_W{1'b0}}};
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = CYC_W'(DVD_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_nxt = {quo_r[OUT_W-2:0], ge};
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CYC_W'(1);
        if (cnt_r == CYC_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = neg_r ? (~quo_r + OUT_W'(1)) : quo_r;
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // window/smoothing writes drop the history; ring entries are masked by primed
    if (clr) begin
      pos_nxt    = '0;
      primed_nxt = 1'b0;
      sum_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WSZ_W'(8);
      smooth_r    <= 1'b0;
      pos_r       <= '0;
      primed_r    <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      primed_r    <= primed_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) begin
        case (cfg_if.index)
          REG_WINDOW: begin
            win_r <= cfg_if.data[WSZ_W-1:0];
          end
          REG_SMOOTH: begin
            smooth_r <= cfg_if.data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    div_r      <= div_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    ok_r       <= ok_nxt;
    cnt_r      <= cnt_nxt;
    out_temp_r <= out_temp_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= ring[pos_eff];
    end
    if (wr_en) begin
      ring[pos_eff] <= smp_r;
    end
  end

  `TMA_ASSERT(a_pos_in_window, 1'b1, CNT_W'(pos_r) < win_eff)
  `TMA_ASSERT(a_div_nonzero, state_r == S_DIV, div_r != '0)
  `TMA_ASSERT(a_rem_below_div, state_r == S_DIV, rem_r < div_r)
  `TMA_ASSERT_NXT(a_cfg_clears, clr, sum_r == '0 && !primed_r && pos_r == '0)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for temperature_moving_average: directed words at the field extremes
// and special windows, then random traffic under changing register settings,
// each result checked against a local model of the ring-buffer average.
// ----------------------------------------------------------------------------
module tb;
  import tma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          DRAIN_WAIT  = 40;   // margin beyond the averaging path
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp_value;
    logic                    valid_res;
  } temp_result_t;

  logic clk;
  logic rst_n;

  tma_in_if  in_if ();
  tma_out_if out_if ();
  tma_cfg_if cfg_if ();

  temperature_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // model state
  logic [WSZ_W-1:0]        win_reg;
  logic                    smooth_reg;
  logic signed [SMP_W-1:0] hist [WIN_MAX];
  int unsigned             hist_pos;
  bit                      hist_full;
  longint                  hist_sum;

  temp_result_t expected_temps[$];
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_history();
    foreach (hist[i]) hist[i] = '0;
    hist_pos  = 0;
    hist_full = 1'b0;
    hist_sum  = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] val);
    if (idx == REG_WINDOW) begin
      win_reg = val[WSZ_W-1:0];
      clear_history();
    end else if (idx == REG_SMOOTH) begin
      smooth_reg = val[0];
      clear_history();
    end
  endfunction

  function automatic temp_result_t average_temp(input logic [RAW_W-1:0] raw,
                                                input logic ok);
    temp_result_t            r;
    logic signed [SMP_W-1:0] sample;
    int unsigned             n;
    int unsigned             p;
    longint                  cnt;
    longint                  avg;
    sample = $signed(raw[RAW_W-1:2]);
    r = '0;
    if (!ok) return r;
    r.valid_res = 1'b1;
    if (smooth_reg) begin
      n = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
      p = (hist_pos >= n) ? 0 : hist_pos;
      hist_sum = hist_sum - hist[p] + sample;
      hist[p]  = sample;
      p++;
      if (p >= n) begin
        p = 0;
        hist_full = 1'b1;
      end
      hist_pos = p;
      cnt = longint'(hist_full ? n : p);
      if (cnt == 0) cnt = 1;
      avg = (hist_sum * 16) / cnt;
      r.temp_value = avg[OUT_W-1:0];
    end else begin
      r.temp_value = {sample, {FRAC_W{1'b0}}};
    end
    return r;
  endfunction

  // ready toggles at random while stalling is enabled
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    temp_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_temps.size() == 0) begin
        $error("result word with nothing expected: temp_value %0d valid_res %0b",
               out_if.temp_value, out_if.valid_res);
        mismatch_count++;
      end else begin
        want = expected_temps.pop_front();
        if (out_if.temp_value !== want.temp_value) begin
          $error("temp_value: expected %0d, actual %0d", want.temp_value,
                 out_if.temp_value);
          mismatch_count++;
        end
        if (out_if.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0b, actual %0b", want.valid_res,
                 out_if.valid_res);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_word(input logic [RAW_W-1:0] raw, input logic ok);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    cfg_if.valid <= 1'b0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.raw_word <= raw;
    in_if.read_ok  <= ok;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_temps.push_back(average_temp(raw, ok));
  endtask

  // drop valid and let every outstanding word come back
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_temps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg_write(idx, val);
  endtask

  task automatic test_passthrough_extremes();
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h0003, 1'b1);
    send_word(16'hAAAA, 1'b1);
    send_word(16'h7FFC, 1'b0);    // failed read
    send_word(16'h5555, 1'b1);
  endtask

  task automatic test_zero_window();
    wait_idle();
    write_reg(REG_WINDOW, 8'h00);
    write_reg(REG_SMOOTH, 8'h01);
    send_word(16'h1234, 1'b1);
    send_word(16'hFFF8, 1'b1);
    send_word(16'h8001, 1'b1);
  endtask

  task automatic test_sum_extremes();
    wait_idle();
    write_reg(REG_WINDOW, 8'h02);
    send_word(16'h7FFC, 1'b1);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h1111, 1'b0);    // must not disturb the sum
    send_word(16'h8003, 1'b1);
  endtask

  task automatic test_oversized_window();
    wait_idle();
    write_reg(REG_WINDOW, 8'hFF);   // bit 7 dropped, 127 saturates to max
    send_word(16'h7FFC, 1'b1);
    send_word(16'h0004, 1'b1);
    send_word(16'hC000, 1'b1);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_WINDOW, 8'h03);
    send_word(16'h0400, 1'b1);
    send_word(16'h0800, 1'b1);
    wait_idle();
    write_reg(REG_FIRST_UNUSED, 8'hFF);   // history must survive this
    send_word(16'hF000, 1'b1);
    send_word(16'h0010, 1'b1);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_window();
    logic [CFG_DAT_W-1:0] w;
    case ($urandom_range(7))
      0:       w = 8'd0;
      1:       w = CFG_DAT_W'(WIN_MAX);
      2:       w = CFG_DAT_W'($urandom_range(WIN_MAX + 1, 127));
      default: w = CFG_DAT_W'($urandom_range(1, 12));
    endcase
    w[CFG_DAT_W-1] = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    logic [RAW_W-1:0] raw;
    raw = RAW_W'($urandom_range(16'hFFFF));
    case ($urandom_range(7))
      0: raw[RAW_W-1:RAW_W-2] = 2'b01;    // near full scale positive
      1: raw[RAW_W-1:RAW_W-2] = 2'b10;    // near full scale negative
      default: ;
    endcase
    return raw;
  endfunction

  task automatic test_random_traffic(input int unsigned tx_idle,
                                     input int unsigned rx_stall,
                                     input int unsigned n_words);
    int unsigned sent;
    int unsigned seg_len;
    logic [CFG_DAT_W-1:0] d;
    send_idle_pct  = tx_idle;
    recv_stall_pct = rx_stall;
    sent = 0;
    while (sent < n_words) begin
      wait_idle();
      if ($urandom_range(3) != 0) write_reg(REG_WINDOW, pick_window());
      if ($urandom_range(3) != 0) begin
        d = CFG_DAT_W'($urandom_range(255));
        d[0] = ($urandom_range(9) < 8);
        write_reg(REG_SMOOTH, d);
      end
      if ($urandom_range(7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 255)),
                  CFG_DAT_W'($urandom_range(255)));
      seg_len = $urandom_range(20, 140);
      if (seg_len > n_words - sent) seg_len = n_words - sent;
      repeat (seg_len) begin
        send_word(pick_raw(), ($urandom_range(9) != 0));
      end
      sent += seg_len;
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.raw_word <= '0;
    in_if.read_ok  <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    win_reg    = 7'd8;
    smooth_reg = 1'b0;
    clear_history();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_passthrough_extremes();
    test_zero_window();
    test_sum_extremes();
    test_oversized_window();
    test_unused_index();
    test_random_traffic(23, 51, 530);
    test_random_traffic(51, 23, 530);
    test_random_traffic(0, 0, 540);

    wait_idle();
    cfg_if.valid <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tma_pkg.sv
rtl/tma_in_if.sv
rtl/tma_out_if.sv
rtl/tma_cfg_if.sv
rtl/temperature_moving_average.sv
bench/tb.sv
